@@ rtl/cpc_pkg.sv @@
`default_nettype none
package cpc_pkg;

    localparam int XW  = 32;  // coordinate word, signed Q16.16
    localparam int PRW = 64;  // products and their saturated differences
    localparam int QW  = 42;  // clamped quotient, +-2^40 signed
    localparam int QLIM_LOG = 40;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_CLIP = 2'd0;
    localparam cmd_t CMD_SUBJ = 2'd1;
    localparam cmd_t CMD_RUN  = 2'd2;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
    } vtx_t;

    typedef struct packed {
        logic                  start;
        logic signed [PRW-1:0] num;
        logic signed [XW-1:0]  scale;
        logic signed [PRW-1:0] den;
    } div_req_t;

endpackage
`default_nettype wire

@@ rtl/cpc_vmem.sv @@
`default_nettype none
module cpc_vmem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  cpc_pkg::vtx_t      wdata,
    input  wire logic [AW-1:0] raddr,
    output cpc_pkg::vtx_t      rdata
);
    import cpc_pkg::*;

    vtx_t mem [DEPTH];
    vtx_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/cpc_div.sv @@
`default_nettype none
module cpc_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  cpc_pkg::div_req_t             req,
    output logic                          done,
    output logic signed [cpc_pkg::QW-1:0] quot
);
    import cpc_pkg::*;

    // The product of a 63-bit and a 32-bit magnitude fits in 96 bits.
    localparam int PW = 96;
    localparam int CW = $clog2(PW);
    localparam logic [QLIM_LOG:0] QLIM = {1'b1, {QLIM_LOG{1'b0}}};

    typedef enum logic [2:0] {DV_IDLE, DV_MUL_LO, DV_MUL_HI, DV_STEP, DV_FIN} dv_state_t;

    dv_state_t               state_reg;
    logic [PRW-1:0]          un_reg;
    logic [XW-1:0]           uk_reg;
    logic [PRW-1:0]          ud_reg;
    logic                    neg_reg;
    logic [PW-1:0]           prod_reg;
    logic [PRW-1:0]          rem_reg;
    logic [QLIM_LOG:0]       q_reg;
    logic                    ovf_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    done_reg;
    logic signed [QW-1:0]    quot_reg;

    logic [2*XW-1:0]         mul_p;
    logic [PRW:0]            r2;
    logic                    qb;
    logic [QLIM_LOG:0]       mag;

    always_comb
    begin
        mul_p = (state_reg == DV_MUL_LO) ? un_reg[XW-1:0] * uk_reg
                                         : un_reg[PRW-1:XW] * uk_reg;
        r2    = {rem_reg, prod_reg[PW-1]};
        qb    = (r2 >= {1'b0, ud_reg});
        mag   = (ovf_reg || q_reg > QLIM) ? QLIM : q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == DV_FIN);
            unique case (state_reg)
                DV_IDLE:
                begin
                    if (req.start)
                    begin
                        un_reg    <= req.num[PRW-1] ? PRW'(-req.num) : req.num;
                        uk_reg    <= req.scale[XW-1] ? XW'(-req.scale) : req.scale;
                        ud_reg    <= req.den[PRW-1] ? PRW'(-req.den) : req.den;
                        neg_reg   <= req.num[PRW-1] ^ req.scale[XW-1] ^ req.den[PRW-1];
                        state_reg <= DV_MUL_LO;
                    end
                end
                DV_MUL_LO:
                begin
                    prod_reg  <= PW'(mul_p);
                    state_reg <= DV_MUL_HI;
                end
                DV_MUL_HI:
                begin
                    prod_reg  <= prod_reg + {mul_p, {XW{1'b0}}};
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    ovf_reg   <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= DV_STEP;
                end
                DV_STEP:
                begin
                    rem_reg  <= qb ? PRW'(r2 - {1'b0, ud_reg}) : r2[PRW-1:0];
                    q_reg    <= {q_reg[QLIM_LOG-1:0], qb};
                    ovf_reg  <= ovf_reg | q_reg[QLIM_LOG];
                    prod_reg <= {prod_reg[PW-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(PW - 1))
                    begin
                        state_reg <= DV_FIN;
                    end
                end
                DV_FIN:
                begin
                    quot_reg  <= neg_reg ? -QW'(mag) : QW'(mag);
                    state_reg <= DV_IDLE;
                end
                default:
                begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

@@ rtl/convex_polygon_clip.sv @@
`default_nettype none
// Sutherland-Hodgman clipper for a clockwise convex clip polygon, signed Q16.16.
// Input channel (in_valid/in_ready): command 0 appends a clip vertex, command 1
// appends a subject vertex, command 2 runs the clip and emits the result. Loads
// beyond MAX_VERTS are dropped and reported on overflow_flag of the next run.
// Output channel (out_valid/out_ready): one item per result vertex, the last one
// marked by final_vertex; an empty polygon gives a single item with zero
// coordinates and empty_result set.
// A run tests every vertex of the current polygon against each clip edge on a
// shared 32x32 multiplier and writes each kept vertex; a crossing takes its
// product terms on that multiplier and then two bit-serial divisions, which are
// skipped when the lines are parallel. The result is then emitted vertex by vertex
// while the receiver keeps up. The vertex memories have a registered read; the
// source and destination polygons sit in opposite halves of the work memory.
// Input is taken only while the block is idle. The output register holds a result
// until it is taken, and the walk waits on it; the last result may still wait while
// the next item is accepted.
// Reset clears the counts and the dropped flag; memory contents stay undefined.
module convex_polygon_clip #(
    parameter int MAX_VERTS   = 8,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  cpc_pkg::cmd_t                      command,
    input  wire logic signed [cpc_pkg::XW-1:0] vert_x,
    input  wire logic signed [cpc_pkg::XW-1:0] vert_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [cpc_pkg::XW-1:0]      out_x,
    output logic signed [cpc_pkg::XW-1:0]      out_y,
    output logic                               final_vertex,
    output logic                               empty_result,
    output logic                               overflow_flag
);
    import cpc_pkg::*;

    localparam int IW   = $clog2(MAX_VERTS);
    localparam int CNTW = $clog2(MAX_VERTS + 1);
    localparam int SW   = 43;
    localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_VERTS);
    localparam logic signed [SW-1:0] CMAX_S = SW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] CMIN_S = -CMAX_S - SW'(1);
    localparam logic signed [PRW:0]  PMAX_S = {2'b00, {(PRW-1){1'b1}}};

    typedef enum logic [4:0] {
        ST_IDLE, ST_EDGE_RA, ST_EDGE_RB, ST_EDGE_DB, ST_S_CAP, ST_E_RD, ST_E_CAP,
        ST_IN_D, ST_IN_M1, ST_IN_M2, ST_IN_C, ST_DECIDE,
        ST_X_D, ST_X_M1, ST_X_M2, ST_X_DD, ST_X_M3, ST_X_M4, ST_X_N,
        ST_DIV_X, ST_WAIT_X, ST_DIV_Y, ST_WAIT_Y, ST_PUSH, ST_NEXT,
        ST_OUT_START, ST_OUT_RD, ST_OUT_LD
    } state_t;

    function automatic logic signed [XW-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [XW-1:0] r;
        if (v > CMAX_S)
        begin
            r = CMAX_S[XW-1:0];
        end
        else if (v < CMIN_S)
        begin
            r = CMIN_S[XW-1:0];
        end
        else
        begin
            r = v[XW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [XW-1:0] dif(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
        logic signed [SW-1:0] t;
        t = SW'(a) - SW'(b);
        return sat_c(t);
    endfunction

    function automatic logic signed [PRW-1:0] sat64(input logic signed [PRW-1:0] p,
                                                    input logic signed [PRW-1:0] q);
        logic signed [PRW:0]   t;
        logic signed [PRW-1:0] r;
        t = (PRW+1)'(p) - (PRW+1)'(q);
        if (t > PMAX_S)
        begin
            r = PMAX_S[PRW-1:0];
        end
        else if (t < -PMAX_S)
        begin
            r = PRW'(-PMAX_S);
        end
        else
        begin
            r = t[PRW-1:0];
        end
        return r;
    endfunction

    state_t                 state_reg;
    logic [CNTW-1:0]        clip_cnt_reg;
    logic [CNTW-1:0]        work_cnt_reg;
    logic                   drop_reg;
    logic [CNTW-1:0]        i_reg;
    logic [CNTW-1:0]        j_reg;
    logic [CNTW-1:0]        n_reg;
    logic [CNTW-1:0]        m_reg;
    logic                   bank_reg;
    vtx_t                   a_reg;
    vtx_t                   s_reg;
    vtx_t                   e_reg;
    vtx_t                   p_reg;
    vtx_t                   pv_reg;
    logic signed [XW-1:0]   bdx_reg;
    logic signed [XW-1:0]   bdy_reg;
    logic signed [XW-1:0]   dpx_reg;
    logic signed [XW-1:0]   dpy_reg;
    logic signed [XW-1:0]   ex_reg;
    logic signed [XW-1:0]   ey_reg;
    logic signed [PRW-1:0]  prod_a_reg;
    logic signed [PRW-1:0]  prod_b_reg;
    logic signed [PRW-1:0]  d_reg;
    logic signed [PRW-1:0]  num_reg;
    logic                   sin_reg;
    logic                   ein_reg;
    logic                   eval_s_reg;
    logic                   push_e_reg;
    logic                   out_valid_reg;
    vtx_t                   out_v_reg;
    logic                   final_reg;
    logic                   empty_reg;
    logic                   ovf_reg;

    logic                   clip_we;
    logic [IW-1:0]          clip_waddr;
    logic [IW-1:0]          clip_raddr;
    vtx_t                   clip_rdata;
    logic                   work_we;
    logic [IW:0]            work_waddr;
    vtx_t                   work_wdata;
    logic [IW:0]            work_raddr;
    vtx_t                   work_rdata;
    vtx_t                   load_v;

    logic signed [XW-1:0]   mul_a;
    logic signed [XW-1:0]   mul_b;
    logic signed [PRW-1:0]  mul_p;

    div_req_t               div_req;
    logic                   div_done;
    logic signed [QW-1:0]   div_quot;
    logic signed [XW-1:0]   div_coord;

    logic                   in_acc;
    logic                   can_load;
    logic                   out_load;
    logic [CNTW-1:0]        i_inc;
    logic [CNTW-1:0]        i_next;
    logic [CNTW-1:0]        j_inc;
    logic [CNTW-1:0]        n_m1;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;
    assign out_load = can_load && (((state_reg == ST_OUT_START) && (n_reg == '0))
                                   || (state_reg == ST_OUT_LD));
    assign i_inc    = i_reg + CNTW'(1);
    assign i_next   = (i_inc == clip_cnt_reg) ? '0 : i_inc;
    assign j_inc    = j_reg + CNTW'(1);
    assign n_m1     = n_reg - CNTW'(1);
    assign load_v.x = sat_c(SW'(vert_x));
    assign load_v.y = sat_c(SW'(vert_y));

    always_comb
    begin
        clip_we    = in_acc && (command == CMD_CLIP) && (clip_cnt_reg < MAXC);
        clip_waddr = clip_cnt_reg[IW-1:0];
        clip_raddr = (state_reg == ST_EDGE_RB) ? i_next[IW-1:0] : i_reg[IW-1:0];

        if (state_reg == ST_PUSH)
        begin
            work_we    = (m_reg < MAXC);
            work_waddr = {~bank_reg, m_reg[IW-1:0]};
            work_wdata = pv_reg;
        end
        else
        begin
            work_we    = in_acc && (command == CMD_SUBJ) && (work_cnt_reg < MAXC);
            work_waddr = {1'b0, work_cnt_reg[IW-1:0]};
            work_wdata = load_v;
        end
        work_raddr = (state_reg == ST_EDGE_DB) ? {bank_reg, n_m1[IW-1:0]}
                                               : {bank_reg, j_reg[IW-1:0]};
    end

    // One shared multiplier for the inside tests and the crossing terms.
    always_comb
    begin
        unique case (state_reg)
            ST_IN_M1: begin mul_a = bdx_reg; mul_b = dpy_reg; end
            ST_IN_M2: begin mul_a = bdy_reg; mul_b = dpx_reg; end
            ST_X_M1:  begin mul_a = ey_reg;  mul_b = bdx_reg; end
            ST_X_M2:  begin mul_a = ex_reg;  mul_b = bdy_reg; end
            ST_X_M3:  begin mul_a = ex_reg;  mul_b = dpy_reg; end
            ST_X_M4:  begin mul_a = ey_reg;  mul_b = dpx_reg; end
            default:  begin mul_a = bdx_reg; mul_b = dpy_reg; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y);
        div_req.num   = num_reg;
        div_req.scale = (state_reg == ST_DIV_Y) ? bdy_reg : bdx_reg;
        div_req.den   = d_reg;
        div_coord     = sat_c(SW'((state_reg == ST_WAIT_Y) ? a_reg.y : a_reg.x)
                              + SW'(div_quot));
    end

    cpc_vmem #(.DEPTH(MAX_VERTS), .AW(IW)) u_clip_mem (
        .clk   (clk),
        .we    (clip_we),
        .waddr (clip_waddr),
        .wdata (load_v),
        .raddr (clip_raddr),
        .rdata (clip_rdata)
    );

    cpc_vmem #(.DEPTH(2 ** (IW + 1)), .AW(IW + 1)) u_work_mem (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rdata)
    );

    cpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clip_cnt_reg  <= '0;
            work_cnt_reg  <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            m_reg         <= '0;
            bank_reg      <= 1'b0;
            sin_reg       <= 1'b0;
            ein_reg       <= 1'b0;
            eval_s_reg    <= 1'b0;
            push_e_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        unique case (command)
                            CMD_CLIP:
                            begin
                                if (clip_cnt_reg < MAXC)
                                    clip_cnt_reg <= clip_cnt_reg + CNTW'(1);
                                else
                                    drop_reg <= 1'b1;
                            end
                            CMD_SUBJ:
                            begin
                                if (work_cnt_reg < MAXC)
                                    work_cnt_reg <= work_cnt_reg + CNTW'(1);
                                else
                                    drop_reg <= 1'b1;
                            end
                            CMD_RUN:
                            begin
                                i_reg    <= '0;
                                m_reg    <= '0;
                                bank_reg <= 1'b0;
                                n_reg    <= work_cnt_reg;
                                if (clip_cnt_reg == '0 || work_cnt_reg == '0)
                                    state_reg <= ST_OUT_START;
                                else
                                    state_reg <= ST_EDGE_RA;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_EDGE_RA:
                begin
                    state_reg <= ST_EDGE_RB;
                end
                ST_EDGE_RB:
                begin
                    a_reg     <= clip_rdata;
                    state_reg <= ST_EDGE_DB;
                end
                ST_EDGE_DB:
                begin
                    bdx_reg   <= dif(clip_rdata.x, a_reg.x);
                    bdy_reg   <= dif(clip_rdata.y, a_reg.y);
                    state_reg <= ST_S_CAP;
                end
                ST_S_CAP:
                begin
                    s_reg      <= work_rdata;
                    p_reg      <= work_rdata;
                    eval_s_reg <= 1'b1;
                    state_reg  <= ST_IN_D;
                end
                ST_E_RD:
                begin
                    state_reg <= ST_E_CAP;
                end
                ST_E_CAP:
                begin
                    e_reg      <= work_rdata;
                    p_reg      <= work_rdata;
                    eval_s_reg <= 1'b0;
                    state_reg  <= ST_IN_D;
                end
                ST_IN_D:
                begin
                    dpx_reg   <= dif(p_reg.x, a_reg.x);
                    dpy_reg   <= dif(p_reg.y, a_reg.y);
                    state_reg <= ST_IN_M1;
                end
                ST_IN_M1:
                begin
                    prod_a_reg <= mul_p;
                    state_reg  <= ST_IN_M2;
                end
                ST_IN_M2:
                begin
                    prod_b_reg <= mul_p;
                    state_reg  <= ST_IN_C;
                end
                ST_IN_C:
                begin
                    // A point on the edge line counts as inside.
                    if (eval_s_reg)
                    begin
                        sin_reg   <= (prod_a_reg <= prod_b_reg);
                        j_reg     <= '0;
                        state_reg <= ST_E_RD;
                    end
                    else
                    begin
                        ein_reg   <= (prod_a_reg <= prod_b_reg);
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (ein_reg && !sin_reg)
                    begin
                        push_e_reg <= 1'b1;
                        state_reg  <= ST_X_D;
                    end
                    else if (ein_reg)
                    begin
                        push_e_reg <= 1'b0;
                        pv_reg     <= e_reg;
                        state_reg  <= ST_PUSH;
                    end
                    else if (sin_reg)
                    begin
                        push_e_reg <= 1'b0;
                        state_reg  <= ST_X_D;
                    end
                    else
                    begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_X_D:
                begin
                    ex_reg    <= dif(e_reg.x, s_reg.x);
                    ey_reg    <= dif(e_reg.y, s_reg.y);
                    dpx_reg   <= dif(a_reg.x, s_reg.x);
                    dpy_reg   <= dif(a_reg.y, s_reg.y);
                    state_reg <= ST_X_M1;
                end
                ST_X_M1:
                begin
                    prod_a_reg <= mul_p;
                    state_reg  <= ST_X_M2;
                end
                ST_X_M2:
                begin
                    prod_b_reg <= mul_p;
                    state_reg  <= ST_X_DD;
                end
                ST_X_DD:
                begin
                    d_reg     <= sat64(prod_a_reg, prod_b_reg);
                    state_reg <= ST_X_M3;
                end
                ST_X_M3:
                begin
                    prod_a_reg <= mul_p;
                    state_reg  <= ST_X_M4;
                end
                ST_X_M4:
                begin
                    prod_b_reg <= mul_p;
                    state_reg  <= ST_X_N;
                end
                ST_X_N:
                begin
                    num_reg <= sat64(prod_a_reg, prod_b_reg);
                    // Parallel lines: the crossing falls back to the start point.
                    if (d_reg == '0)
                    begin
                        pv_reg    <= s_reg;
                        state_reg <= ST_PUSH;
                    end
                    else
                    begin
                        state_reg <= ST_DIV_X;
                    end
                end
                ST_DIV_X:
                begin
                    state_reg <= ST_WAIT_X;
                end
                ST_WAIT_X:
                begin
                    if (div_done)
                    begin
                        pv_reg.x  <= div_coord;
                        state_reg <= ST_DIV_Y;
                    end
                end
                ST_DIV_Y:
                begin
                    state_reg <= ST_WAIT_Y;
                end
                ST_WAIT_Y:
                begin
                    if (div_done)
                    begin
                        pv_reg.y  <= div_coord;
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (m_reg < MAXC)
                        m_reg <= m_reg + CNTW'(1);
                    else
                        drop_reg <= 1'b1;
                    if (push_e_reg)
                    begin
                        pv_reg     <= e_reg;
                        push_e_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    s_reg   <= e_reg;
                    sin_reg <= ein_reg;
                    if (j_inc == n_reg)
                    begin
                        bank_reg <= ~bank_reg;
                        n_reg    <= m_reg;
                        i_reg    <= i_inc;
                        if (i_inc == clip_cnt_reg || m_reg == '0)
                        begin
                            state_reg <= ST_OUT_START;
                        end
                        else
                        begin
                            m_reg     <= '0;
                            state_reg <= ST_EDGE_RA;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_inc;
                        state_reg <= ST_E_RD;
                    end
                end
                ST_OUT_START:
                begin
                    j_reg <= '0;
                    if (n_reg != '0)
                    begin
                        state_reg <= ST_OUT_RD;
                    end
                    else if (can_load)
                    begin
                        out_v_reg     <= '0;
                        final_reg     <= 1'b1;
                        empty_reg     <= 1'b1;
                        ovf_reg       <= drop_reg;
                        clip_cnt_reg  <= '0;
                        work_cnt_reg  <= '0;
                        drop_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD:
                begin
                    if (can_load)
                    begin
                        out_v_reg     <= work_rdata;
                        final_reg     <= (j_inc == n_reg);
                        empty_reg     <= 1'b0;
                        ovf_reg       <= drop_reg;
                        if (j_inc == n_reg)
                        begin
                            clip_cnt_reg <= '0;
                            work_cnt_reg <= '0;
                            drop_reg     <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_inc;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_v_reg.x;
    assign out_y         = out_v_reg.y;
    assign final_vertex  = final_reg;
    assign empty_result  = empty_reg;
    assign overflow_flag = ovf_reg;

    a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_result |-> final_vertex)
        else $error("empty result not marked as the last item");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        clip_cnt_reg <= MAXC && work_cnt_reg <= MAXC && m_reg <= MAXC)
        else $error("vertex count beyond capacity");

    a_push_to_dst: assert property (@(posedge clk) disable iff (!rst_n)
        work_we && state_reg != ST_IDLE |-> work_waddr[IW] != bank_reg)
        else $error("clipping stage writes into its own source polygon");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_done)
        else $error("divider finished right after start");

endmodule
`default_nettype wire

@@ tb/sv/tb_convex_polygon_clip.sv @@
module tb_convex_polygon_clip;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NV         = 8;
    localparam int  CYCLE_CAP  = 3000000;
    localparam int  ITEM_GOAL  = 330;
    localparam longint WMAX    = 64'sd2147483647;
    localparam longint WMIN    = -64'sd2147483648;
    localparam logic signed [65:0] P63 = 66'sh7FFFFFFFFFFFFFFF;

    typedef struct {
        longint x;
        longint y;
    } pt_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        bit          fin;
        bit          emp;
        bit          ovf;
    } vert_res_t;

    typedef struct {
        cpc_pkg::cmd_t cmd;
        logic [31:0]   x;
        logic [31:0]   y;
        bit            is_empty_run;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    cpc_pkg::cmd_t        command;
    logic signed [31:0]   vert_x;
    logic signed [31:0]   vert_y;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [31:0]   out_x;
    logic signed [31:0]   out_y;
    logic                 final_vertex;
    logic                 empty_result;
    logic                 overflow_flag;

    pt_t       clip_pts[NV];
    pt_t       subj_pts[NV];
    int        clip_n;
    int        subj_n;
    bit        drop_seen;
    vert_res_t pending_verts[$];
    int        mismatch_cnt;
    int        items_sent;
    int        cyc;
    int        snd_idle;
    int        rcv_idle;

    convex_polygon_clip DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .vert_x(vert_x),
        .vert_y(vert_y),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_x(out_x),
        .out_y(out_y),
        .final_vertex(final_vertex),
        .empty_result(empty_result),
        .overflow_flag(overflow_flag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint sat_w(longint v);
        if (v > WMAX)
            return WMAX;
        if (v < WMIN)
            return WMIN;
        return v;
    endfunction

    function automatic longint diff_w(longint a, longint b);
        return sat_w(a - b);
    endfunction

    function automatic longint sub_sat64(longint a, longint b);
        logic signed [65:0] wa;
        logic signed [65:0] wb;
        logic signed [65:0] r;
        wa = a;
        wb = b;
        r = wa - wb;
        if (r > P63)
            return longint'(P63);
        if (r < -P63)
            return -longint'(P63);
        return longint'(r);
    endfunction

    function automatic bit on_inner_side(pt_t a, pt_t b, pt_t p);
        longint c;
        c = sub_sat64(diff_w(b.x, a.x) * diff_w(p.y, a.y),
                      diff_w(b.y, a.y) * diff_w(p.x, a.x));
        return c <= 0;
    endfunction

    // n*k/d exactly, truncated toward zero and clamped to +-2^40.
    function automatic longint scaled_ratio(longint n, longint k, longint d);
        logic signed [127:0] wn;
        logic signed [127:0] wk;
        logic signed [127:0] wd;
        logic signed [127:0] pr;
        logic [127:0]        up;
        logic [127:0]        ud;
        logic [127:0]        q;
        bit                  neg;
        wn = n;
        wk = k;
        wd = d;
        pr = wn * wk;
        neg = ((n < 0) != (k < 0)) != (d < 0);
        up = (pr < 0) ? -pr : pr;
        ud = (wd < 0) ? -wd : wd;
        q = up / ud;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic pt_t edge_crossing(pt_t a, pt_t b, pt_t s, pt_t e);
        longint ex;
        longint ey;
        longint bx;
        longint by;
        longint d;
        longint n;
        pt_t    r;
        ex = diff_w(e.x, s.x);
        ey = diff_w(e.y, s.y);
        bx = diff_w(b.x, a.x);
        by = diff_w(b.y, a.y);
        d = sub_sat64(ey * bx, ex * by);
        n = sub_sat64(ex * diff_w(a.y, s.y), ey * diff_w(a.x, s.x));
        if (d == 0)
            return s;
        r.x = sat_w(a.x + scaled_ratio(n, bx, d));
        r.y = sat_w(a.y + scaled_ratio(n, by, d));
        return r;
    endfunction

    // Advances the polygon state by one accepted item and queues its results.
    task automatic apply_item(input cpc_pkg::cmd_t c, input logic signed [31:0] x,
                              input logic signed [31:0] y, input bit is_empty_run);
        pt_t       v;
        pt_t       a;
        pt_t       b;
        pt_t       s;
        pt_t       e;
        pt_t       cur[NV];
        pt_t       nxt[NV];
        int        n;
        int        m;
        bit        drop;
        bit        ein;
        bit        sin;
        vert_res_t r;
        v.x = x;
        v.y = y;
        case (c)
            cpc_pkg::CMD_CLIP:
            begin
                if (clip_n >= NV)
                    drop_seen = 1'b1;
                else
                begin
                    clip_pts[clip_n] = v;
                    clip_n++;
                end
            end
            cpc_pkg::CMD_SUBJ:
            begin
                if (subj_n >= NV)
                    drop_seen = 1'b1;
                else
                begin
                    subj_pts[subj_n] = v;
                    subj_n++;
                end
            end
            cpc_pkg::CMD_RUN:
            begin
                n = subj_n;
                cur = subj_pts;
                drop = drop_seen;
                for (int i = 0; i < clip_n && n > 0; i++)
                begin
                    a = clip_pts[i];
                    b = clip_pts[(i + 1) % clip_n];
                    s = cur[n - 1];
                    m = 0;
                    for (int j = 0; j < n; j++)
                    begin
                        e = cur[j];
                        ein = on_inner_side(a, b, e);
                        sin = on_inner_side(a, b, s);
                        if (ein != sin)
                        begin
                            if (m >= NV)
                                drop = 1'b1;
                            else
                            begin
                                nxt[m] = edge_crossing(a, b, s, e);
                                m++;
                            end
                        end
                        if (ein)
                        begin
                            if (m >= NV)
                                drop = 1'b1;
                            else
                            begin
                                nxt[m] = e;
                                m++;
                            end
                        end
                        s = e;
                    end
                    cur = nxt;
                    n = m;
                end
                if (is_empty_run)
                    pending_verts.push_back('{32'd0, 32'd0, 1'b1, 1'b1, 1'b0});
                else if (n == 0)
                    pending_verts.push_back('{32'd0, 32'd0, 1'b1, 1'b1, drop});
                else
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        r.x = cur[i].x[31:0];
                        r.y = cur[i].y[31:0];
                        r.fin = (i + 1 == n);
                        r.emp = 1'b0;
                        r.ovf = drop;
                        pending_verts.push_back(r);
                    end
                end
                clip_n = 0;
                subj_n = 0;
                drop_seen = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_item(input cpc_pkg::cmd_t c, input logic [31:0] x,
                             input logic [31:0] y, input bit is_empty_run);
        @(negedge clk);
        if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < snd_idle);
        end
        in_valid <= 1'b1;
        command <= c;
        vert_x <= x;
        vert_y <= y;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        apply_item(c, x, y, is_empty_run);
        items_sent++;
    endtask

    // A clockwise convex polygon from a subset of eight compass directions and a subject
    // scattered around it, in either order, followed by a run.
    task automatic send_polygon_pair();
        longint   dx[NV];
        longint   dy[NV];
        longint   cx;
        longint   cy;
        longint   rad;
        int       mask;
        int       nsub;
        int       nextra;
        bit       huge;
        bit       subj_first;
        dx = '{1000, 707, 0, -707, -1000, -707, 0, 707};
        dy = '{0, -707, -1000, -707, 0, 707, 1000, 707};
        huge = ($urandom_range(0, 11) == 0);
        if (huge)
        begin
            cx = longint'($signed($urandom()));
            cy = longint'($signed($urandom()));
            rad = $urandom_range(1 << 20, 1 << 30);
        end
        else
        begin
            cx = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            cy = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            rad = $urandom_range(1 << 12, 1 << 19);
        end
        do
            mask = $urandom_range(0, 255);
        while ($countones(mask) < 3);
        if ($urandom_range(0, 9) == 0)
            mask = 8'hFF;
        nextra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
        nsub = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 10) : $urandom_range(3, 8);
        subj_first = $urandom_range(0, 3) == 0;
        for (int pass = 0; pass < 2; pass++)
        begin
            if ((pass == 0) != subj_first)
            begin
                for (int i = 0; i < NV; i++)
                    if (mask[i])
                        send_item(cpc_pkg::CMD_CLIP,
                                  32'(sat_w(cx + dx[i] * rad / 1000)),
                                  32'(sat_w(cy + dy[i] * rad / 1000)), 1'b0);
                for (int i = 0; i < nextra; i++)
                    send_item(cpc_pkg::CMD_CLIP, $urandom(), $urandom(), 1'b0);
            end
            else
            begin
                for (int i = 0; i < nsub; i++)
                    send_item(cpc_pkg::CMD_SUBJ,
                              32'(sat_w(cx + longint'($urandom_range(0, 4000)) * rad / 1000
                                        - 2 * rad)),
                              32'(sat_w(cy + longint'($urandom_range(0, 4000)) * rad / 1000
                                        - 2 * rad)), 1'b0);
            end
        end
        if ($urandom_range(0, 19) == 0)
            send_item(cpc_pkg::cmd_t'(2'd3), $urandom(), $urandom(), 1'b0);
        send_item(cpc_pkg::CMD_RUN, $urandom(), $urandom(), 1'b0);
    endtask

    always @(negedge clk)
        out_ready <= (rcv_idle == 0) || ($urandom_range(0, 99) >= rcv_idle);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verts.size() == 0)
            begin
                $error("vertex with no result pending: x=%0h y=%0h", out_x, out_y);
                mismatch_cnt++;
            end
            else
            begin
                vert_res_t w;
                w = pending_verts.pop_front();
                if (out_x !== w.x)
                begin
                    $error("out_x: expected %0h, actual %0h", w.x, out_x);
                    mismatch_cnt++;
                end
                if (out_y !== w.y)
                begin
                    $error("out_y: expected %0h, actual %0h", w.y, out_y);
                    mismatch_cnt++;
                end
                if (final_vertex !== w.fin)
                begin
                    $error("final_vertex: expected %0b, actual %0b", w.fin, final_vertex);
                    mismatch_cnt++;
                end
                if (empty_result !== w.emp)
                begin
                    $error("empty_result: expected %0b, actual %0b", w.emp, empty_result);
                    mismatch_cnt++;
                end
                if (overflow_flag !== w.ovf)
                begin
                    $error("overflow_flag: expected %0b, actual %0b", w.ovf, overflow_flag);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_CAP)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows[$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        command = cpc_pkg::CMD_CLIP;
        vert_x = '0;
        vert_y = '0;
        clip_n = 0;
        subj_n = 0;
        drop_seen = 1'b0;
        mismatch_cnt = 0;
        items_sent = 0;
        cyc = 0;
        snd_idle = 25;
        rcv_idle = 46;
        // Run on empty polygons, unknown command, extremes with no clip polygon,
        // a square clip, a clip at the range extremes, a lone clip vertex.
        rows = '{
            '{cpc_pkg::CMD_RUN,  32'h0,        32'h0,        1'b1},
            '{cpc_pkg::cmd_t'(2'd3), 32'h80000000, 32'h7FFFFFFF, 1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h80000000, 32'h80000000, 1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h7FFFFFFF, 32'h80000000, 1'b0},
            '{cpc_pkg::CMD_RUN,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0},
            '{cpc_pkg::CMD_CLIP, 32'h0,        32'h0,        1'b0},
            '{cpc_pkg::CMD_CLIP, 32'h0,        32'hA0000,    1'b0},
            '{cpc_pkg::CMD_CLIP, 32'hA0000,    32'hA0000,    1'b0},
            '{cpc_pkg::CMD_CLIP, 32'hA0000,    32'h0,        1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'hFFFB0000, 32'h50000,    1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h50000,    32'hF0000,    1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'hF0000,    32'hFFFB0000, 1'b0},
            '{cpc_pkg::CMD_RUN,  32'h0,        32'h0,        1'b0},
            '{cpc_pkg::CMD_CLIP, 32'h80000000, 32'h80000000, 1'b0},
            '{cpc_pkg::CMD_CLIP, 32'h80000000, 32'h7FFFFFFF, 1'b0},
            '{cpc_pkg::CMD_CLIP, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h0,        32'h0,        1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h7FFFFFFF, 32'h80000000, 1'b0},
            '{cpc_pkg::CMD_SUBJ, 32'h80000000, 32'h0,        1'b0},
            '{cpc_pkg::CMD_RUN,  32'h0,        32'h0,        1'b0},
            '{cpc_pkg::CMD_CLIP, 32'h10000,    32'h10000,    1'b0},
            '{cpc_pkg::CMD_RUN,  32'h0,        32'h0,        1'b1}
        };
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        foreach (rows[i])
            send_item(rows[i].cmd, rows[i].x, rows[i].y, rows[i].is_empty_run);
        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent > ITEM_GOAL / 3)
            begin
                snd_idle = 46;
                rcv_idle = 25;
            end
            if (items_sent > 2 * ITEM_GOAL / 3)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // Noise: any command with full-range coordinates.
                repeat ($urandom_range(1, 6))
                    send_item(cpc_pkg::cmd_t'($urandom_range(0, 3)), $urandom(),
                              $urandom(), 1'b0);
            end
            else
                send_polygon_pair();
        end
        send_item(cpc_pkg::CMD_RUN, 32'h0, 32'h0, 1'b0);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verts.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
        if (mismatch_cnt == 0 && pending_verts.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cpc_pkg.sv
rtl/cpc_vmem.sv
rtl/cpc_div.sv
rtl/convex_polygon_clip.sv
tb/sv/tb_convex_polygon_clip.sv
